// File: rtl/plt_pkg.sv
// Shared types and constants of the positional list engine.
// Used by plt_cell, plt_chain and positional_list_engine_unit; depends on nothing.

package plt_pkg;

  // List geometry
  localparam int CAPACITY   = 128;
  localparam int VALUE_BITS = 16;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Beat field widths
  localparam int OP_BITS     = 3;
  localparam int POS_BITS    = 8;
  localparam int ITEM_BITS   = 16;
  localparam int STATUS_BITS = 2;
  localparam int OUTVAL_BITS = 16;
  localparam int COUNT_BITS  = 8;

  // Width wide enough to compare a position against the count
  localparam int CMP_W = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

  localparam int IN_BITS     = OP_BITS + POS_BITS + ITEM_BITS;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_BITS + OUTVAL_BITS + COUNT_BITS;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_BITS-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_AT    = 3'd1,
    OP_INS_BACK  = 3'd2,
    OP_REM_FRONT = 3'd3,
    OP_REM_AT    = 3'd4,
    OP_REM_BACK  = 3'd5,
    OP_READ      = 3'd6
  } plt_op_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } plt_status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [CNT_W-1:0]      at;
    logic [VALUE_BITS-1:0] item;
  } plt_cmd_t;

endpackage

// File: rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: request decode, count, result register.
// Depends on plt_pkg and plt_chain.

// An ordered list of up to CAPACITY entries kept in a row of cells. Each
// request beat inserts, removes or reads at the front, the back or a given
// position and returns one result beat with status, value and new count. A
// request is done at the edge that takes it: every cell compares its index
// with the position and shifts on it, so a new beat is taken each cycle
// while the result register is empty or being drained. A failed request
// leaves the list untouched; unused operation codes answer ok with count.

module positional_list_engine_unit import plt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [2:0] operation, [10:3] position, [26:11] item_value, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] status, [17:2] out_value, [25:18] entry_count, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [OP_BITS-1:0]   op_w;
  logic [POS_BITS-1:0]  pos_w;
  logic [ITEM_BITS-1:0] item_w;
  logic [CMP_W-1:0]     pos_cmp, cnt_cmp;

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  plt_status_e      status_q, status_d;
  logic [OUTVAL_BITS-1:0] value_q;
  logic [COUNT_BITS-1:0]  ecount_q;

  logic             accept;
  logic             is_full, is_empty, take;
  logic [CNT_W-1:0] at_d;
  plt_cmd_t         cmd;
  logic [VALUE_BITS-1:0] sel_value;

  assign op_w   = s_axis_tdata_i[OP_BITS-1:0];
  assign pos_w  = s_axis_tdata_i[OP_BITS+POS_BITS-1:OP_BITS];
  assign item_w = s_axis_tdata_i[IN_BITS-1:OP_BITS+POS_BITS];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_cmp  = CMP_W'(pos_w);
  assign cnt_cmp  = CMP_W'(count_q);
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    status_d = ST_OK;
    at_d     = '0;
    cmd.ins  = 1'b0;
    cmd.rem  = 1'b0;
    take     = 1'b0;
    case (op_w)
      OP_INS_FRONT: begin
        status_d = is_full ? ST_FULL : ST_OK;
        cmd.ins  = !is_full;
      end
      OP_INS_BACK: begin
        status_d = is_full ? ST_FULL : ST_OK;
        at_d     = count_q;
        cmd.ins  = !is_full;
      end
      OP_INS_AT: begin
        at_d = pos_cmp[CNT_W-1:0];
        if (is_full) begin
          status_d = ST_FULL;
        end else if (pos_cmp > cnt_cmp) begin
          status_d = ST_BADPOS;
        end else begin
          cmd.ins = 1'b1;
        end
      end
      OP_REM_FRONT: begin
        status_d = is_empty ? ST_EMPTY : ST_OK;
        cmd.rem  = !is_empty;
        take     = !is_empty;
      end
      OP_REM_BACK: begin
        status_d = is_empty ? ST_EMPTY : ST_OK;
        at_d     = count_q - CNT_W'(1);
        cmd.rem  = !is_empty;
        take     = !is_empty;
      end
      OP_REM_AT, OP_READ: begin
        at_d = pos_cmp[CNT_W-1:0];
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else if (pos_cmp >= cnt_cmp) begin
          status_d = ST_BADPOS;
        end else begin
          cmd.rem = (op_w == OP_REM_AT);
          take    = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
    // drop the update unless the beat is really taken
    cmd.ins  = cmd.ins && accept;
    cmd.rem  = cmd.rem && accept;
    cmd.at   = at_d;
    cmd.item = VALUE_BITS'(item_w);
  end

  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd.rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  plt_chain u_chain (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .sel_value_o (sel_value)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      value_q  <= take ? OUTVAL_BITS'(sel_value) : '0;
      ecount_q <= COUNT_BITS'(count_d);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'({ecount_q, value_q, status_q});

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("list count above capacity");

  // A failed request leaves the count alone
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status_d != ST_OK) |=> count_q == $past(count_q))
    else $error("failed request changed the count");

  // A successful insert grows the list by one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (status_d == ST_OK) &&
    ((op_w == OP_INS_FRONT) || (op_w == OP_INS_AT) || (op_w == OP_INS_BACK))
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  // Every accepted beat produces a pending result
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("accepted beat produced no result");

endmodule

// File: rtl/plt_cell.sv
// One list slot: holds an entry and shifts toward or away from its neighbors.
// Depends on plt_pkg for the command struct and widths.

module plt_cell import plt_pkg::*; (
  input  logic                  clk_i,
  input  logic [CNT_W-1:0]      idx_i,    // fixed slot index
  input  plt_cmd_t              cmd_i,
  input  logic [VALUE_BITS-1:0] lower_i,  // value of slot idx-1
  input  logic [VALUE_BITS-1:0] upper_i,  // value of slot idx+1
  output logic [VALUE_BITS-1:0] value_o,
  output logic [VALUE_BITS-1:0] tap_o     // own value when idx equals cmd position, else zero
);

  logic [VALUE_BITS-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      // open a slot: move up above the position, take the new item at it
      if (idx_i > cmd_i.at) begin
        value_d = lower_i;
      end else if (idx_i == cmd_i.at) begin
        value_d = cmd_i.item;
      end
    end else if (cmd_i.rem && (idx_i >= cmd_i.at)) begin
      // close the slot: pull down from above
      value_d = upper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = (idx_i == cmd_i.at) ? value_q : '0;

endmodule

// File: rtl/plt_chain.sv
// Row of CAPACITY list cells wired to their neighbors, plus the tap gather.
// Depends on plt_pkg and plt_cell.

module plt_chain import plt_pkg::*; (
  input  logic                  clk_i,
  input  plt_cmd_t              cmd_i,
  output logic [VALUE_BITS-1:0] sel_value_o   // entry at cmd position before the update
);

  logic [VALUE_BITS-1:0] value_w [CAPACITY];
  logic [VALUE_BITS-1:0] tap_w   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] lower_w, upper_w;

    if (i == 0) begin : g_first
      assign lower_w = cmd_i.item;
    end else begin : g_lower
      assign lower_w = value_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = value_w[i];
    end else begin : g_upper
      assign upper_w = value_w[i+1];
    end

    plt_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (CNT_W'(i)),
      .cmd_i   (cmd_i),
      .lower_i (lower_w),
      .upper_i (upper_w),
      .value_o (value_w[i]),
      .tap_o   (tap_w[i])
    );
  end

  // At most one cell taps, so an OR gathers it
  always_comb begin
    sel_value_o = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_value_o = sel_value_o | tap_w[k];
    end
  end

endmodule

// File: verif/tb_top.sv
// Self-checking bench for positional_list_engine_unit: list edits, reads, full/empty and
// position errors against an in-bench queue predictor, with random stalls on both streams.
// Depends on plt_pkg and the RTL under rtl/.
`timescale 1ns / 100ps

module tb_top;
  import plt_pkg::*;

  localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

  typedef struct packed {
    plt_status_e            status;
    logic [OUTVAL_BITS-1:0] value;
    logic [COUNT_BITS-1:0]  entries;
  } list_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  // [2:0] operation, [10:3] position, [26:11] item_value, rest zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  // [1:0] status, [17:2] out_value, [25:18] entry_count, rest zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  logic [VALUE_BITS-1:0] list_model[$];
  list_result_t          list_results[$];
  int                    fail_count = 0;
  int                    sink_hold = 0;
  bit                    steady_flow = 1'b1;

  positional_list_engine_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Mostly short pauses, now and then a long one
  function automatic int pause_len();
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Apply one request to the list copy and return the result it must produce
  function automatic list_result_t apply_request(logic [OP_BITS-1:0] op,
                                                 logic [POS_BITS-1:0] pos,
                                                 logic [ITEM_BITS-1:0] item);
    list_result_t res;
    int           n;
    n = list_model.size();
    res.status = ST_OK;
    res.value  = '0;
    case (op)
      OP_INS_FRONT, OP_INS_AT, OP_INS_BACK: begin
        if (n >= CAPACITY) res.status = ST_FULL;
        else if (op == OP_INS_FRONT) list_model.push_front(item[VALUE_BITS-1:0]);
        else if (op == OP_INS_BACK) list_model.push_back(item[VALUE_BITS-1:0]);
        else if (pos > n) res.status = ST_BADPOS;
        else list_model.insert(pos, item[VALUE_BITS-1:0]);
      end
      OP_REM_FRONT, OP_REM_AT, OP_REM_BACK, OP_READ: begin
        if (n == 0) res.status = ST_EMPTY;
        else if (op == OP_REM_FRONT) res.value = OUTVAL_BITS'(list_model.pop_front());
        else if (op == OP_REM_BACK) res.value = OUTVAL_BITS'(list_model.pop_back());
        else if (pos >= n) res.status = ST_BADPOS;
        else begin
          res.value = OUTVAL_BITS'(list_model[pos]);
          if (op == OP_REM_AT) list_model.delete(pos);
        end
      end
      default: ;
    endcase
    res.entries = COUNT_BITS'(list_model.size());
    return res;
  endfunction

  task automatic send_request(input logic [OP_BITS-1:0] op, input logic [POS_BITS-1:0] pos,
                              input logic [ITEM_BITS-1:0] item);
    int gap;
    gap = (!steady_flow && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = IN_TDATA_W'({item, pos, op});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    list_results.push_back(apply_request(op, pos, item));
  endtask

  // One random request; ins_pct steers the fill level up or down
  task automatic send_random(input int ins_pct);
    int                    n;
    int                    r;
    logic [OP_BITS-1:0]    op;
    logic [POS_BITS-1:0]   pos;
    n   = list_model.size();
    r   = $urandom_range(0, 99);
    pos = POS_BITS'($urandom_range(0, 255));
    if (r < 4) begin
      op = OP_BITS'($urandom_range(0, 7));
    end else if (r < 16) begin
      op = OP_READ;
      if (n > 0 && $urandom_range(0, 7) != 0) pos = POS_BITS'($urandom_range(0, n - 1));
    end else if ($urandom_range(0, 99) < ins_pct) begin
      op = OP_BITS'($urandom_range(OP_INS_FRONT, OP_INS_BACK));
      if ($urandom_range(0, 9) != 0) pos = POS_BITS'($urandom_range(0, n));
    end else begin
      op = OP_BITS'($urandom_range(OP_REM_FRONT, OP_REM_BACK));
      if (n > 0 && $urandom_range(0, 9) != 0) pos = POS_BITS'($urandom_range(0, n - 1));
    end
    send_request(op, pos, ITEM_BITS'($urandom_range(0, 16'hFFFF)));
  endtask

  task automatic test_empty_list();
    send_request(OP_REM_FRONT, 8'd0, 16'h0000);
    send_request(OP_REM_AT, 8'd0, 16'hFFFF);
    send_request(OP_REM_BACK, 8'd255, 16'h0000);
    send_request(OP_READ, 8'd255, 16'hFFFF);
    send_request(OP_UNUSED, 8'd255, 16'hFFFF);
    send_request(OP_INS_AT, 8'd1, 16'h1111);
    send_request(OP_INS_AT, 8'd0, 16'hFFFF);
  endtask

  task automatic test_list_edits();
    send_request(OP_INS_FRONT, 8'd255, 16'h0000);
    send_request(OP_INS_BACK, 8'd0, 16'h8001);
    send_request(OP_INS_AT, 8'd1, 16'h5A5A);
    // position equal to count appends
    send_request(OP_INS_AT, 8'd4, 16'h1234);
    send_request(OP_INS_AT, 8'd255, 16'hA5A5);
    send_request(OP_INS_AT, 8'd128, 16'hA5A5);
    send_request(OP_READ, 8'd0, 16'hFFFF);
    send_request(OP_READ, 8'd4, 16'h0000);
    send_request(OP_READ, 8'd5, 16'h0000);
    send_request(OP_READ, 8'd128, 16'h0000);
    send_request(OP_REM_AT, 8'd5, 16'h0000);
    send_request(OP_REM_AT, 8'd2, 16'h0000);
    send_request(OP_REM_BACK, 8'd0, 16'h0000);
    send_request(OP_REM_FRONT, 8'd0, 16'h0000);
    send_request(OP_UNUSED, 8'd0, 16'h0000);
    send_request(OP_REM_AT, 8'd1, 16'h0000);
    send_request(OP_REM_FRONT, 8'd7, 16'h0000);
  endtask

  task automatic test_fill_and_drain();
    steady_flow = 1'b0;
    while (list_model.size() < CAPACITY) send_random(90);
    // every insert kind must report full, bad position included
    send_request(OP_INS_FRONT, 8'd0, 16'hFFFF);
    send_request(OP_INS_AT, 8'd200, 16'hFFFF);
    send_request(OP_INS_BACK, 8'd0, 16'hFFFF);
    send_request(OP_READ, 8'(CAPACITY - 1), 16'h0000);
    send_request(OP_READ, 8'(CAPACITY), 16'h0000);
    send_request(OP_REM_AT, 8'(CAPACITY), 16'h0000);
    while (list_model.size() > 0) send_random(10);
  endtask

  task automatic test_random_walk(input int legs);
    int target;
    int r;
    for (int leg = 0; leg < legs; leg++) begin
      steady_flow = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      target = (r < 30) ? 0 : (r < 60) ? CAPACITY : $urandom_range(1, CAPACITY - 1);
      repeat (100) send_random((list_model.size() < target) ? 80 : 20);
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    if (sink_hold > 0) sink_hold--;
    else if (!steady_flow && $urandom_range(0, 4) == 0) sink_hold = pause_len();
    m_axis_tready_i = (sink_hold == 0);
  end

  always @(posedge clk_i) begin : check_results
    list_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (list_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time,
                 m_axis_tdata_o);
        fail_count++;
      end else begin
        want = list_results.pop_front();
        check_field("status", want.status, m_axis_tdata_o[STATUS_BITS-1:0]);
        check_field("out_value", want.value, m_axis_tdata_o[STATUS_BITS +: OUTVAL_BITS]);
        check_field("entry_count", want.entries,
                    m_axis_tdata_o[STATUS_BITS+OUTVAL_BITS +: COUNT_BITS]);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_empty_list();
    test_list_edits();
    test_fill_and_drain();
    test_random_walk(12);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (list_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
